@@ hw/rtl/rfp_pkg.sv @@
// shared types, constants and helpers for the radar frame parser
// no dependencies; compiled first

package rfp_pkg;

    // largest payload length that is accepted
    localparam logic [15:0] MAX_PAYLOAD = 16'd64;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_WORD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOOTER_WORD = 2'd1;

    localparam logic [31:0] HEADER_WORD_RESET = 32'hF1F2_F3F4;
    localparam logic [31:0] FOOTER_WORD_RESET = 32'hF5F6_F7F8;

    // target status codes; MOVING and MOVE_STILL mean a moving target
    localparam logic [7:0] STATUS_NONE       = 8'h00;
    localparam logic [7:0] STATUS_MOVING     = 8'h01;
    localparam logic [7:0] STATUS_MOVE_STILL = 8'h03;

    // payload byte positions that are kept
    localparam logic [15:0] POS_STATUS   = 16'd2;
    localparam logic [15:0] POS_MOVE_LO  = 16'd3;
    localparam logic [15:0] POS_MOVE_HI  = 16'd4;
    localparam logic [15:0] POS_STILL_LO = 16'd5;
    localparam logic [15:0] POS_STILL_HI = 16'd6;

    // minimum lengths for a result and for each distance
    localparam logic [15:0] LEN_RESULT = 16'd4;
    localparam logic [15:0] LEN_MOVE   = 16'd5;
    localparam logic [15:0] LEN_STILL  = 16'd7;

    typedef struct packed {
        logic [31:0] header_word;
        logic [31:0] footer_word;
    } cfg_regs_t;

    typedef struct packed {
        logic        presence;
        logic        motion;
        logic [15:0] distance_cm;
        logic [7:0]  target_status;
    } result_t;

    // byte idx of a 4-byte word, first byte in bits 7:0
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
        word_byte = w[{idx, 3'b000} +: 8];
    endfunction

endpackage

@@ hw/rtl/rfp_byte_if.sv @@
// byte stream channel: valid, ready and one received byte
// depends on nothing

interface rfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/rfp_result_if.sv @@
// result channel: valid, ready and the decoded target fields
// depends on nothing

interface rfp_result_if;
    logic        valid;
    logic        ready;
    logic        presence;
    logic        motion;
    logic [15:0] distance_cm;
    logic [7:0]  target_status;

    modport source (output valid, output presence, output motion, output distance_cm,
                    output target_status, input ready);
    modport sink (input valid, input presence, input motion, input distance_cm,
                  input target_status, output ready);
endinterface

@@ hw/rtl/rfp_cfg_if.sv @@
// configuration write channel: valid, ready, register index and data
// depends on rfp_pkg

interface rfp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rfp_pkg::CFG_INDEX_W-1:0]  index;
    logic [31:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rfp_cfg_regs.sv @@
// header and footer word registers written through the config channel
// depends on rfp_pkg, rfp_cfg_if

module rfp_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    rfp_cfg_if.sink            cfg,
    output rfp_pkg::cfg_regs_t regs
);

    logic [31:0] header_word_reg;
    logic [31:0] footer_word_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_word_reg <= rfp_pkg::HEADER_WORD_RESET;
            footer_word_reg <= rfp_pkg::FOOTER_WORD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                rfp_pkg::CFG_HEADER_WORD: header_word_reg <= cfg.data;
                rfp_pkg::CFG_FOOTER_WORD: footer_word_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign regs.header_word = header_word_reg;
    assign regs.footer_word = footer_word_reg;

endmodule

@@ hw/rtl/rfp_frame_fsm.sv @@
// per-byte frame state machine: header, length, payload capture, footer
// depends on rfp_pkg; emits a one-cycle result strobe

module rfp_frame_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_fire,
    input  logic [7:0]         rx_byte,
    input  rfp_pkg::cfg_regs_t regs,
    output logic               res_fire,
    output rfp_pkg::result_t   res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_FOOTER = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  match_reg, match_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pidx_reg, pidx_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] move_reg, move_next;
    logic [15:0] still_reg, still_next;

    logic [15:0] len_full;
    logic [15:0] pidx_inc;
    logic        moving;

    assign len_full = {rx_byte, len_reg[7:0]};
    assign pidx_inc = pidx_reg + 16'd1;
    assign moving   = (status_reg == rfp_pkg::STATUS_MOVING) ||
                      (status_reg == rfp_pkg::STATUS_MOVE_STILL);

    always_comb
    begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        len_next    = len_reg;
        pidx_next   = pidx_reg;
        status_next = status_reg;
        move_next   = move_reg;
        still_next  = still_reg;
        res_fire    = 1'b0;

        res.presence      = status_reg != rfp_pkg::STATUS_NONE;
        res.motion        = moving;
        res.target_status = status_reg;
        res.distance_cm   = 16'd0;
        if (len_reg >= rfp_pkg::LEN_MOVE)
        begin
            if (moving)
                res.distance_cm = move_reg;
            else if (len_reg >= rfp_pkg::LEN_STILL)
                res.distance_cm = still_reg;
        end

        if (byte_fire)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte == rfp_pkg::word_byte(regs.header_word, match_reg))
                    begin
                        if (match_reg == 2'd3)
                        begin
                            phase_next = PH_LENGTH;
                            match_next = 2'd0;
                            pidx_next  = 16'd0;
                        end
                        else
                            match_next = match_reg + 2'd1;
                    end
                    else
                        // a mismatching byte may still open a new header
                        match_next = (rx_byte == regs.header_word[7:0]) ? 2'd1 : 2'd0;
                end
                PH_LENGTH:
                begin
                    if (pidx_reg == 16'd0)
                    begin
                        len_next  = {8'd0, rx_byte};
                        pidx_next = 16'd1;
                    end
                    else if (len_full > rfp_pkg::MAX_PAYLOAD)
                    begin
                        phase_next = PH_HEADER;
                        match_next = 2'd0;
                        len_next   = 16'd0;
                        pidx_next  = 16'd0;
                    end
                    else
                    begin
                        len_next   = len_full;
                        phase_next = PH_DATA;
                        pidx_next  = 16'd0;
                    end
                end
                PH_DATA:
                begin
                    // empty payload still swallows one byte here
                    if (pidx_reg < len_reg)
                    begin
                        case (pidx_reg)
                            rfp_pkg::POS_STATUS:   status_next       = rx_byte;
                            rfp_pkg::POS_MOVE_LO:  move_next[7:0]    = rx_byte;
                            rfp_pkg::POS_MOVE_HI:  move_next[15:8]   = rx_byte;
                            rfp_pkg::POS_STILL_LO: still_next[7:0]   = rx_byte;
                            rfp_pkg::POS_STILL_HI: still_next[15:8]  = rx_byte;
                            default: ;
                        endcase
                        pidx_next = pidx_inc;
                    end
                    if (pidx_next >= len_reg)
                    begin
                        phase_next = PH_FOOTER;
                        match_next = 2'd0;
                    end
                end
                default:
                begin
                    if (rx_byte != rfp_pkg::word_byte(regs.footer_word, match_reg) ||
                        match_reg == 2'd3)
                    begin
                        phase_next = PH_HEADER;
                        match_next = 2'd0;
                        len_next   = 16'd0;
                        pidx_next  = 16'd0;
                        res_fire   = (rx_byte ==
                                      rfp_pkg::word_byte(regs.footer_word, match_reg)) &&
                                     (len_reg >= rfp_pkg::LEN_RESULT);
                    end
                    else
                        match_next = match_reg + 2'd1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            match_reg <= 2'd0;
            len_reg   <= 16'd0;
            pidx_reg  <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            len_reg   <= len_next;
            pidx_reg  <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        move_reg   <= move_next;
        still_reg  <= still_next;
    end

`ifndef SYNTHESIS
    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA || phase_reg == PH_FOOTER) |-> len_reg <= rfp_pkg::MAX_PAYLOAD)
        else $error("payload length above limit past length phase");

    a_pidx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> pidx_reg <= len_reg)
        else $error("payload index ran past payload length");

    a_len_phase_pidx: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LENGTH) |-> pidx_reg <= 16'd1)
        else $error("length phase index out of range");

    a_fire_at_footer_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> (byte_fire && phase_reg == PH_FOOTER && match_reg == 2'd3))
        else $error("result outside last footer byte");

    a_fire_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |=> (phase_reg == PH_HEADER && match_reg == 2'd0 && len_reg == 16'd0))
        else $error("parser did not restart after result");
`endif

endmodule

@@ hw/rtl/rfp_out_reg.sv @@
// output register between the frame logic and the result channel
// depends on rfp_pkg, rfp_result_if

module rfp_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rfp_pkg::result_t res,
    output logic             space,
    rfp_result_if.source     result
);

    logic             valid_reg, valid_next;
    rfp_pkg::result_t data_reg;

    // a held result drains in the same cycle a new one loads
    assign space      = !valid_reg || result.ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign result.valid         = valid_reg;
    assign result.presence      = data_reg.presence;
    assign result.motion        = data_reg.motion;
    assign result.distance_cm   = data_reg.distance_cm;
    assign result.target_status = data_reg.target_status;

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result.ready && !load) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> space)
        else $error("result loaded over an untaken one");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result.ready && !load) |=> !valid_reg)
        else $error("taken result not cleared");
`endif

endmodule

@@ hw/rtl/radar_frame_parser.sv @@
// top level of the radar frame parser
// depends on rfp_pkg, the rfp channel interfaces, rfp_cfg_regs, rfp_frame_fsm, rfp_out_reg

// Parses the serial byte stream of a presence radar, one byte per request and
// up to one byte per clock. A frame is four header bytes, a little-endian 16-bit
// payload length, the payload and four footer bytes; header and footer bytes
// come from two config registers (index 0 header, index 1 footer, first byte in
// bits 7:0). Lengths above 64 drop the frame. A clean frame with length 4 or more
// yields one result request carrying presence, motion, raw target status and the
// distance in cm. The result is registered and shows up the clock after the last
// footer byte is taken. The per-byte state update sits between the accepted byte
// and the output register, and rx.ready drops only while a result waits untaken
// at the output. Config writes are always ready and belong to idle periods.

module radar_frame_parser (
    input  logic          clk,
    input  logic          rst_n,
    rfp_cfg_if.sink       cfg,
    rfp_byte_if.sink      rx,
    rfp_result_if.source  result
);

    rfp_pkg::cfg_regs_t regs;
    rfp_pkg::result_t   res;
    logic               res_fire;
    logic               space;
    logic               byte_fire;

    // byte requests stall only behind a waiting result
    assign rx.ready  = space;
    assign byte_fire = rx.valid && rx.ready;

    rfp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // header, length, payload capture and footer checks
    rfp_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .rx_byte   (rx.rx_byte),
        .regs      (regs),
        .res_fire  (res_fire),
        .res       (res)
    );

    // result holding stage
    rfp_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_fire),
        .res    (res),
        .space  (space),
        .result (result)
    );

endmodule

@@ bench/radar_frame_parser_tb.sv @@
`timescale 1ns / 100ps

// self-checking bench for radar_frame_parser: a directed frame table, then random frames
// with varied header and footer words, random idling on both channels and a long output stall
// depends on rfp_pkg, the rfp channel interfaces and the radar_frame_parser rtl

module radar_frame_parser_tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int TARGET_BYTES   = 1450;
    // settling time after the last owed report, as slack behind the registered result
    localparam int LATENCY_CYCLES = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 160;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int N_DIRECTED     = 18;

    // indexes past the two registers, writes there must be ignored
    localparam logic [rfp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rfp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [2:0] {
        FRAME_GOOD,
        FRAME_RESYNC,       // partial header first, then a full header
        FRAME_OVERSIZE,     // header and a length above the limit, nothing more
        FRAME_BAD_FOOTER,   // footer cut short by one corrupted byte
        FRAME_NOISE         // len random bytes, no framing
    } frame_kind_e;

    typedef enum logic [1:0] {
        PH_WAIT_HEADER,
        PH_READ_LENGTH,
        PH_READ_DATA,
        PH_WAIT_FOOTER
    } parse_phase_e;

    typedef struct packed {
        frame_kind_e      kind;
        logic [15:0]      len;
        logic [7:0]       status;
        logic [15:0]      move_cm;
        logic [15:0]      still_cm;
        logic             typed;      // expectation comes from typed_has / typed_res
        logic             typed_has;
        rfp_pkg::result_t typed_res;
    } frame_row_t;

    localparam rfp_pkg::result_t NO_RESULT = '0;

    // directed frames, all at the reset header and footer words
    localparam frame_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // right after reset: moving target at the largest distance
        '{FRAME_GOOD, 16'd7, rfp_pkg::STATUS_MOVING, 16'hFFFF, 16'h1234, 1'b1, 1'b1,
          '{1'b1, 1'b1, 16'hFFFF, rfp_pkg::STATUS_MOVING}},
        // no target: stationary distance is reported
        '{FRAME_GOOD, 16'd7, rfp_pkg::STATUS_NONE, 16'h0000, 16'hFFFF, 1'b1, 1'b1,
          '{1'b0, 1'b0, 16'hFFFF, rfp_pkg::STATUS_NONE}},
        '{FRAME_GOOD, 16'd7, rfp_pkg::STATUS_MOVE_STILL, 16'h0000, 16'h8001, 1'b1, 1'b1,
          '{1'b1, 1'b1, 16'h0000, rfp_pkg::STATUS_MOVE_STILL}},
        '{FRAME_GOOD, 16'd7, 8'h02, 16'h5555, 16'hABCD, 1'b1, 1'b1,
          '{1'b1, 1'b0, 16'hABCD, 8'h02}},
        // moving target but the distance bytes are missing
        '{FRAME_GOOD, 16'd4, rfp_pkg::STATUS_MOVING, 16'h7777, 16'h7777, 1'b1, 1'b1,
          '{1'b1, 1'b1, 16'h0000, rfp_pkg::STATUS_MOVING}},
        '{FRAME_GOOD, 16'd5, rfp_pkg::STATUS_MOVING, 16'h0102, 16'h0000,
          1'b0, 1'b0, NO_RESULT},
        // still target, stationary distance not in payload
        '{FRAME_GOOD, 16'd6, 8'h02, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
          '{1'b1, 1'b0, 16'h0000, 8'h02}},
        // short frame
        '{FRAME_GOOD, 16'd3, rfp_pkg::STATUS_MOVING, 16'h0000, 16'h0000,
          1'b1, 1'b0, NO_RESULT},
        // zero length, one filler byte before the footer
        '{FRAME_GOOD, 16'd0, rfp_pkg::STATUS_NONE, 16'h0000, 16'h0000,
          1'b1, 1'b0, NO_RESULT},
        '{FRAME_GOOD, 16'd1, rfp_pkg::STATUS_NONE, 16'h0000, 16'h0000,
          1'b0, 1'b0, NO_RESULT},
        // length just past the limit, then the largest length
        '{FRAME_OVERSIZE, 16'd65, rfp_pkg::STATUS_NONE, 16'h0000, 16'h0000,
          1'b1, 1'b0, NO_RESULT},
        '{FRAME_OVERSIZE, 16'hFFFF, rfp_pkg::STATUS_NONE, 16'h0000, 16'h0000,
          1'b1, 1'b0, NO_RESULT},
        // longest accepted payload
        '{FRAME_GOOD, 16'd64, 8'hFF, 16'h1111, 16'h0001, 1'b1, 1'b1,
          '{1'b1, 1'b0, 16'h0001, 8'hFF}},
        '{FRAME_BAD_FOOTER, 16'd7, rfp_pkg::STATUS_MOVING, 16'h2222, 16'h3333,
          1'b1, 1'b0, NO_RESULT},
        // header mismatch that restarts on the first header byte
        '{FRAME_RESYNC, 16'd8, rfp_pkg::STATUS_MOVING, 16'h0102, 16'h0304, 1'b1, 1'b1,
          '{1'b1, 1'b1, 16'h0102, rfp_pkg::STATUS_MOVING}},
        '{FRAME_GOOD, 16'd5, rfp_pkg::STATUS_NONE, 16'h4444, 16'h5555,
          1'b0, 1'b0, NO_RESULT},
        '{FRAME_NOISE, 16'd6, rfp_pkg::STATUS_NONE, 16'h0000, 16'h0000,
          1'b0, 1'b0, NO_RESULT},
        '{FRAME_GOOD, 16'd8, 8'hAA, 16'h6666, 16'h7788, 1'b0, 1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    rfp_cfg_if    cfg ();
    rfp_byte_if   rx ();
    rfp_result_if result ();

    radar_frame_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .rx     (rx),
        .result (result)
    );

    // tracked copy of the registers and of the parser state
    logic [31:0]  hdr_word_trk;
    logic [31:0]  ftr_word_trk;
    parse_phase_e trk_phase;
    logic [2:0]   trk_match;
    logic [15:0]  trk_len;
    logic [15:0]  trk_pos;
    logic [7:0]   trk_status;
    logic [15:0]  trk_move;
    logic [15:0]  trk_still;

    // target reports still owed by the block, oldest first
    rfp_pkg::result_t pending_reports[$];
    logic [7:0]       frame_bytes[$];

    int  errors;
    int  bytes_sent;
    int  frames_sent;
    int  reports_seen;
    int  cfg_writes;
    int  cycle_count;
    bit  calm;        // no idling on either side
    bit  hold_req;    // asks the receiver for one long stall
    bit  use_typed;   // current row carries its own expectation

    rfp_pkg::result_t got_report;
    rfp_pkg::result_t want_report;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // byte k of a 4-byte word, first byte in bits 7:0
    function automatic logic [7:0] lane(input logic [31:0] w, input logic [2:0] k);
        return 8'(w >> (8 * k[1:0]));
    endfunction

    task automatic tracker_restart();
        trk_phase = PH_WAIT_HEADER;
        trk_match = 3'd0;
        trk_len   = 16'd0;
        trk_pos   = 16'd0;
    endtask

    // advance the tracked parser by one accepted byte
    task automatic predict_frame_byte(input logic [7:0] b, output bit produced,
                                      output rfp_pkg::result_t res);
        logic [15:0] len_keep;
        produced = 1'b0;
        res      = '0;
        case (trk_phase)
            PH_WAIT_HEADER:
            begin
                if (b == lane(hdr_word_trk, trk_match))
                begin
                    trk_match = trk_match + 3'd1;
                    if (trk_match >= 3'd4)
                    begin
                        trk_phase = PH_READ_LENGTH;
                        trk_match = 3'd0;
                        trk_pos   = 16'd0;
                    end
                end
                else
                begin
                    // restart on the first header byte
                    trk_match = (b == lane(hdr_word_trk, 3'd0)) ? 3'd1 : 3'd0;
                end
            end
            PH_READ_LENGTH:
            begin
                if (trk_pos == 16'd0)
                begin
                    trk_len = {8'h00, b};
                    trk_pos = 16'd1;
                end
                else
                begin
                    trk_len = trk_len | {b, 8'h00};
                    if (trk_len > rfp_pkg::MAX_PAYLOAD)
                        tracker_restart();
                    else
                    begin
                        trk_phase = PH_READ_DATA;
                        trk_pos   = 16'd0;
                    end
                end
            end
            PH_READ_DATA:
            begin
                // zero length falls through and still eats this byte
                if (trk_pos < trk_len)
                begin
                    case (trk_pos)
                        rfp_pkg::POS_STATUS:   trk_status      = b;
                        rfp_pkg::POS_MOVE_LO:  trk_move[7:0]   = b;
                        rfp_pkg::POS_MOVE_HI:  trk_move[15:8]  = b;
                        rfp_pkg::POS_STILL_LO: trk_still[7:0]  = b;
                        rfp_pkg::POS_STILL_HI: trk_still[15:8] = b;
                        default: ;
                    endcase
                    trk_pos = trk_pos + 16'd1;
                end
                if (trk_pos >= trk_len)
                begin
                    trk_phase = PH_WAIT_FOOTER;
                    trk_match = 3'd0;
                end
            end
            default:
            begin
                if (b != lane(ftr_word_trk, trk_match))
                    tracker_restart();
                else
                begin
                    trk_match = trk_match + 3'd1;
                    if (trk_match >= 3'd4)
                    begin
                        len_keep = trk_len;
                        tracker_restart();
                        if (len_keep >= rfp_pkg::LEN_RESULT)
                        begin
                            produced          = 1'b1;
                            res.presence      = (trk_status != rfp_pkg::STATUS_NONE);
                            res.motion        = (trk_status == rfp_pkg::STATUS_MOVING) ||
                                                (trk_status == rfp_pkg::STATUS_MOVE_STILL);
                            res.distance_cm   = 16'd0;
                            res.target_status = trk_status;
                            if (len_keep >= rfp_pkg::LEN_MOVE)
                            begin
                                if (res.motion)
                                    res.distance_cm = trk_move;
                                else if (len_keep >= rfp_pkg::LEN_STILL)
                                    res.distance_cm = trk_still;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    // turn one row into the bytes on the wire, using the current words
    task automatic build_frame(input frame_row_t row);
        int bad_k;
        frame_bytes.delete();
        if (row.kind == FRAME_NOISE)
        begin
            // sprinkle first header bytes so the restart path sees noise too
            for (int i = 0; i < row.len; i++)
                frame_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                      lane(hdr_word_trk, 3'd0) : 8'($urandom));
        end
        else
        begin
            if (row.kind == FRAME_RESYNC)
            begin
                frame_bytes.push_back(lane(hdr_word_trk, 3'd0));
                frame_bytes.push_back(lane(hdr_word_trk, 3'd1));
            end
            for (int k = 0; k < 4; k++)
                frame_bytes.push_back(lane(hdr_word_trk, 3'(k)));
            frame_bytes.push_back(row.len[7:0]);
            frame_bytes.push_back(row.len[15:8]);
            if (row.kind != FRAME_OVERSIZE)
            begin
                if (row.len == 16'd0)
                    frame_bytes.push_back(8'($urandom));
                for (int i = 0; i < row.len; i++)
                begin
                    case (16'(i))
                        rfp_pkg::POS_STATUS:   frame_bytes.push_back(row.status);
                        rfp_pkg::POS_MOVE_LO:  frame_bytes.push_back(row.move_cm[7:0]);
                        rfp_pkg::POS_MOVE_HI:  frame_bytes.push_back(row.move_cm[15:8]);
                        rfp_pkg::POS_STILL_LO: frame_bytes.push_back(row.still_cm[7:0]);
                        rfp_pkg::POS_STILL_HI: frame_bytes.push_back(row.still_cm[15:8]);
                        default:               frame_bytes.push_back(8'($urandom));
                    endcase
                end
                if (row.kind == FRAME_BAD_FOOTER)
                begin
                    bad_k = $urandom_range(0, 3);
                    for (int k = 0; k <= bad_k; k++)
                        frame_bytes.push_back((k == bad_k) ?
                            lane(ftr_word_trk, 3'(k)) ^ (8'h01 << $urandom_range(0, 7)) :
                            lane(ftr_word_trk, 3'(k)));
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                        frame_bytes.push_back(lane(ftr_word_trk, 3'(k)));
                end
            end
        end
    endtask

    // one byte request; valid stays high into the next byte when there is no gap
    task automatic send_byte(input logic [7:0] b);
        int               gap;
        bit               produced;
        rfp_pkg::result_t res;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        predict_frame_byte(b, produced, res);
        if (produced && !use_typed)
            pending_reports.push_back(res);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_row_t row);
        build_frame(row);
        use_typed = row.typed;
        // typed rows queue their report up front; the tracker still follows the bytes
        if (row.typed && row.typed_has)
            pending_reports.push_back(row.typed_res);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        use_typed = 1'b0;
        frames_sent++;
    endtask

    // stop offering bytes, let every owed report arrive, then let the pipe settle
    task automatic wait_drained();
        rx.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    // leaves valid high; program_words lowers it after the last write
    task automatic write_reg(input logic [rfp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == rfp_pkg::CFG_HEADER_WORD)
            hdr_word_trk = value;
        else if (idx == rfp_pkg::CFG_FOOTER_WORD)
            ftr_word_trk = value;
        cfg_writes++;
    endtask

    task automatic program_words(input logic [31:0] hdr, input logic [31:0] ftr,
                                 input bit touch_spare);
        write_reg(rfp_pkg::CFG_HEADER_WORD, hdr);
        write_reg(rfp_pkg::CFG_FOOTER_WORD, ftr);
        if (touch_spare)
        begin
            write_reg(CFG_SPARE_A, ~hdr);
            write_reg(CFG_SPARE_B, ~ftr);
        end
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic frame_row_t random_row();
        frame_row_t row;
        int pick;
        row  = '0;
        pick = $urandom_range(0, 99);
        if (pick < 66)
            row.kind = FRAME_GOOD;
        else if (pick < 74)
            row.kind = FRAME_RESYNC;
        else if (pick < 80)
            row.kind = FRAME_OVERSIZE;
        else if (pick < 88)
            row.kind = FRAME_BAD_FOOTER;
        else
            row.kind = FRAME_NOISE;

        pick = $urandom_range(0, 99);
        if (row.kind == FRAME_NOISE)
            row.len = 16'($urandom_range(1, 6));
        else if (row.kind == FRAME_OVERSIZE)
            row.len = (pick < 25) ? 16'd65 : (pick < 50) ? 16'hFFFF :
                      16'($urandom_range(65, 65535));
        else if (pick < 60)
            row.len = 16'($urandom_range(4, 8));
        else if (pick < 75)
            row.len = 16'($urandom_range(0, 3));
        else
            row.len = 16'($urandom_range(9, 64));

        // status skewed toward the codes that change the decode
        case ($urandom_range(0, 5))
            0:       row.status = rfp_pkg::STATUS_NONE;
            1:       row.status = rfp_pkg::STATUS_MOVING;
            2:       row.status = rfp_pkg::STATUS_MOVE_STILL;
            3:       row.status = 8'h02;
            4:       row.status = 8'hFF;
            default: row.status = 8'($urandom);
        endcase
        row.move_cm  = 16'($urandom);
        row.still_cm = 16'($urandom);
        return row;
    endfunction

    // receiver: random stall per report, or one long stall when asked
    initial
    begin
        int stall;
        bit hold_taken;
        hold_taken   = 1'b0;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                stall      = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            else
                stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid && !(hold_req && !hold_taken))
                @(posedge clk);
        end
    end

    // every report request taken is checked against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            reports_seen++;
            got_report = '{result.presence, result.motion, result.distance_cm,
                           result.target_status};
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report presence=%0b motion=%0b dist=%0d status=%02h",
                         $time, got_report.presence, got_report.motion,
                         got_report.distance_cm, got_report.target_status);
            end
            else
            begin
                want_report = pending_reports.pop_front();
                if (got_report !== want_report)
                begin
                    errors++;
                    $display("%0t: mismatch expected presence=%0b motion=%0b dist=%0d st=%02h",
                             $time, want_report.presence, want_report.motion,
                             want_report.distance_cm, want_report.target_status);
                    $display("%0t:            actual presence=%0b motion=%0b dist=%0d st=%02h",
                             $time, got_report.presence, got_report.motion,
                             got_report.distance_cm, got_report.target_status);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d reports still owed", $time, pending_reports.size());
        $display("radar_frame_parser regression: fail");
        $finish;
    end

    initial
    begin
        frame_row_t  row;
        int          phase;
        int          n_frames;
        logic [31:0] hdr;
        logic [31:0] ftr;

        // every input known from time zero
        rst_n        <= 1'b0;
        rx.valid     <= 1'b0;
        rx.rx_byte   <= 8'h00;
        cfg.valid    <= 1'b0;
        cfg.index    <= rfp_pkg::CFG_HEADER_WORD;
        cfg.data     <= 32'h0;

        hdr_word_trk = rfp_pkg::HEADER_WORD_RESET;
        ftr_word_trk = rfp_pkg::FOOTER_WORD_RESET;
        tracker_restart();
        trk_status   = 8'h00;
        trk_move     = 16'h0;
        trk_still    = 16'h0;
        errors       = 0;
        bytes_sent   = 0;
        frames_sent  = 0;
        reports_seen = 0;
        cfg_writes   = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        use_typed    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset words
        for (int r = 0; r < N_DIRECTED; r++)
            send_frame(DIRECTED_ROWS[r]);
        wait_drained();

        // back pressure: receiver stalls long while back-to-back frames keep coming,
        // so the output register fills and the byte input has to stall
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (4)
        begin
            row      = random_row();
            row.kind = FRAME_GOOD;
            row.len  = 16'($urandom_range(4, 8));
            send_frame(row);
        end
        calm = 1'b0;
        wait_drained();

        // random phases, each at its own header and footer words
        phase = 0;
        while (bytes_sent < TARGET_BYTES)
        begin
            case (phase)
                0: program_words(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
                1: program_words(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
                // self-overlapping header, footer equal to header
                2: program_words(32'h4141_4141, 32'h4141_4141, 1'b0);
                3: program_words(rfp_pkg::HEADER_WORD_RESET, rfp_pkg::FOOTER_WORD_RESET, 1'b1);
                default:
                begin
                    hdr = $urandom;
                    ftr = $urandom;
                    if ($urandom_range(0, 3) == 0)
                        hdr = {4{hdr[7:0]}};
                    program_words(hdr, ftr, 1'($urandom_range(0, 1)));
                end
            endcase
            calm     = ($urandom_range(0, 3) == 0);
            n_frames = $urandom_range(8, 20);
            for (int f = 0; f < n_frames && bytes_sent < TARGET_BYTES; f++)
                send_frame(random_row());
            calm = 1'b0;
            // input idles until every report has come before the next words go in
            wait_drained();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames in %0d bytes over %0d register phases",
                 frames_sent, bytes_sent, phase + 1);
        $display("%0d reports checked, %0d register writes, %0d mismatches",
                 reports_seen, cfg_writes, errors);
        if (errors == 0 && pending_reports.size() == 0)
            $display("radar_frame_parser regression: pass");
        else
            $display("radar_frame_parser regression: fail");
        $finish;
    end

endmodule
